/* rtl/core/bdqe_pkg.sv */
// ----------------------------------------------------------------------------
// bdqe_pkg: shared types and constants
// Register indexes, reset values, event structs and the quadrature step table
// for the button debounce and quadrature event core.
// ----------------------------------------------------------------------------
package bdqe_pkg;

  localparam int BUTTON_COUNT_DEF = 6;
  localparam int LONG_CAPABLE_DEF = 4;
  localparam int TIME_WIDTH_DEF   = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MS_W        = 16;
  localparam int DETENT_W    = 4;
  localparam int EVENT_W     = 4;
  localparam int COUNT_W     = 5;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENC_DEBOUNCE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DETENT       = 2'd3;

  localparam logic [MS_W-1:0]     DEBOUNCE_RST     = 16'd25;
  localparam logic [MS_W-1:0]     ENC_DEBOUNCE_RST = 16'd90;
  localparam logic [MS_W-1:0]     LONG_PRESS_RST   = 16'd500;
  localparam logic [DETENT_W-1:0] DETENT_RST       = 4'd4;

  typedef struct packed {
    logic [MS_W-1:0]     debounce_ms;
    logic [MS_W-1:0]     enc_debounce_ms;
    logic [MS_W-1:0]     long_press_ms;
    logic [DETENT_W-1:0] detent_steps;
  } cfg_t;

  typedef struct packed {
    logic click;
    logic long_press;
  } btn_evt_t;

  typedef struct packed {
    logic right;
    logic left;
  } enc_evt_t;

  // quadrature step for a {previous, current} phase pair
  function automatic logic signed [1:0] step_delta(input logic [1:0] prev,
                                                   input logic [1:0] cur);
    logic signed [1:0] d;
    d = 2'sd0;
    case ({prev, cur})
      4'b0001, 4'b0111, 4'b1110, 4'b1000: d = 2'sd1;
      4'b0010, 4'b0100, 4'b1101, 4'b1011: d = -2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

/* rtl/core/button_debounce_and_quadrature_events_core.sv */
// ----------------------------------------------------------------------------
// button_debounce_and_quadrature_events_core: poll-driven button and encoder
// events
// One beat in gives exactly one event_code beat out. The core takes a beat in
// every cycle while out_ready is high: a poll is held in an input register,
// the button filters and the quadrature decoder evaluate it combinationally
// and the event lands in an output register, so the sustained rate is one
// poll per cycle while out_ready stays high. in_ready follows out_ready
// combinationally through the two-entry pipeline. Configuration writes take
// effect at the next edge and should only be made while the core is empty.
// ----------------------------------------------------------------------------
module button_debounce_and_quadrature_events_core #(
  parameter int BUTTON_COUNT = bdqe_pkg::BUTTON_COUNT_DEF,
  parameter int LONG_CAPABLE = bdqe_pkg::LONG_CAPABLE_DEF,
  parameter int TIME_WIDTH   = bdqe_pkg::TIME_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bdqe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bdqe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [TIME_WIDTH-1:0]              time_ms,
  input  logic [BUTTON_COUNT-1:0]            button_levels,
  input  logic                               phase_a,
  input  logic                               phase_b,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bdqe_pkg::EVENT_W-1:0]       event_code
);

  localparam int NLONG      = (LONG_CAPABLE > BUTTON_COUNT) ? BUTTON_COUNT : LONG_CAPABLE;
  localparam int CODE_RIGHT = BUTTON_COUNT + NLONG + 1;
  localparam int CODE_LEFT  = BUTTON_COUNT + NLONG + 2;
  localparam int EVW_MIN    = $clog2(CODE_LEFT + 1);
  localparam int EVW        = (EVW_MIN > bdqe_pkg::EVENT_W) ? EVW_MIN : bdqe_pkg::EVENT_W;

  bdqe_pkg::cfg_t cfg;

  logic                    s1_valid;
  logic [TIME_WIDTH-1:0]   s1_time;
  logic [BUTTON_COUNT-1:0] s1_levels;
  logic [1:0]              s1_phase;
  logic                    s1_fire;

  bdqe_pkg::btn_evt_t      btn_evt [BUTTON_COUNT];
  bdqe_pkg::enc_evt_t      enc_evt;
  logic [EVW-1:0]          btn_code;
  logic [EVW-1:0]          ev_code;
  logic                    enc_fire;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= bdqe_pkg::DEBOUNCE_RST;
      cfg.enc_debounce_ms <= bdqe_pkg::ENC_DEBOUNCE_RST;
      cfg.long_press_ms   <= bdqe_pkg::LONG_PRESS_RST;
      cfg.detent_steps    <= bdqe_pkg::DETENT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bdqe_pkg::REG_DEBOUNCE:     cfg.debounce_ms     <= cfg_data;
        bdqe_pkg::REG_ENC_DEBOUNCE: cfg.enc_debounce_ms <= cfg_data;
        bdqe_pkg::REG_LONG_PRESS:   cfg.long_press_ms   <= cfg_data;
        bdqe_pkg::REG_DETENT:       cfg.detent_steps    <= cfg_data[bdqe_pkg::DETENT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_time   <= time_ms;
      s1_levels <= button_levels;
      s1_phase  <= {phase_a, phase_b};
    end
  end

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
    // the last button is the encoder push and has its own delay
    bdqe_button #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_button (
      .clk     (clk),
      .rst     (rst),
      .fire    (s1_fire),
      .now     (s1_time),
      .raw     (s1_levels[i]),
      .delay   ((i == BUTTON_COUNT - 1) ? cfg.enc_debounce_ms : cfg.debounce_ms),
      .long_ms (cfg.long_press_ms),
      .evt     (btn_evt[i])
    );
  end

  // highest-numbered button wins; long press over click within a button
  always_comb begin
    btn_code = '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (btn_evt[i].click) begin
        btn_code = EVW'(i + 1);
      end
      if ((i < NLONG) && btn_evt[i].long_press) begin
        btn_code = EVW'(BUTTON_COUNT + 1 + i);
      end
    end
  end

  assign enc_fire = s1_fire && (btn_code == '0);

  bdqe_encoder u_encoder (
    .clk          (clk),
    .rst          (rst),
    .fire         (enc_fire),
    .cur          (s1_phase),
    .detent_steps (cfg.detent_steps),
    .evt          (enc_evt)
  );

  always_comb begin
    ev_code = btn_code;
    if (btn_code == '0) begin
      if (enc_evt.right) begin
        ev_code = EVW'(CODE_RIGHT);
      end else if (enc_evt.left) begin
        ev_code = EVW'(CODE_LEFT);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      event_code <= ev_code[bdqe_pkg::EVENT_W-1:0];
    end
  end

endmodule

/* rtl/core/bdqe_button.sv */
// ----------------------------------------------------------------------------
// bdqe_button: one button filter
// Debounce, click on release and one-shot long press detection for a single
// active-low button.
// ----------------------------------------------------------------------------
module bdqe_button #(
  parameter int TIME_WIDTH = bdqe_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [TIME_WIDTH-1:0]       now,
  input  logic                        raw,
  input  logic [bdqe_pkg::MS_W-1:0]   delay,
  input  logic [bdqe_pkg::MS_W-1:0]   long_ms,
  output bdqe_pkg::btn_evt_t          evt
);

  logic                  steady;
  logic                  candidate;
  logic [TIME_WIDTH-1:0] change_time;
  logic [TIME_WIDTH-1:0] press_time;
  logic                  long_reported;

  logic                  moved;
  logic                  settled;
  logic [TIME_WIDTH-1:0] since_change;
  logic [TIME_WIDTH-1:0] held;

  assign moved        = raw != candidate;
  assign since_change = now - change_time;
  assign held         = now - press_time;
  // a fresh change restarts the timer, so only an unchanged level can settle
  assign settled      = !moved && (since_change > TIME_WIDTH'(delay));

  assign evt.click      = settled && raw && !steady && !long_reported &&
                          (held > TIME_WIDTH'(delay));
  assign evt.long_press = settled && !raw && !steady && !long_reported &&
                          (held > TIME_WIDTH'(long_ms));

  always_ff @(posedge clk) begin
    if (rst) begin
      steady        <= 1'b1;
      candidate     <= 1'b1;
      change_time   <= '0;
      press_time    <= '0;
      long_reported <= 1'b0;
    end else if (fire) begin
      if (moved) begin
        candidate   <= raw;
        change_time <= now;
      end
      if (settled && (raw != steady)) begin
        steady <= raw;
        if (!raw) begin
          press_time    <= now;
          long_reported <= 1'b0;
        end
      end
      if (evt.long_press) begin
        long_reported <= 1'b1;
      end
    end
  end

endmodule

/* rtl/core/bdqe_encoder.sv */
// ----------------------------------------------------------------------------
// bdqe_encoder: quadrature decoder
// Signed transition count with detent threshold; reports a step right or
// left and clears the count.
// ----------------------------------------------------------------------------
module bdqe_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic [1:0]                      cur,
  input  logic [bdqe_pkg::DETENT_W-1:0]   detent_steps,
  output bdqe_pkg::enc_evt_t              evt
);

  logic [1:0]                                prev;
  logic signed [bdqe_pkg::COUNT_W-1:0]       count;

  logic                                      changed;
  logic signed [1:0]                         delta;
  logic signed [bdqe_pkg::COUNT_W-1:0]       sum;
  logic signed [bdqe_pkg::COUNT_W-1:0]       det;
  logic [bdqe_pkg::DETENT_W-1:0]             det_u;

  assign changed = cur != prev;
  assign delta   = bdqe_pkg::step_delta(prev, cur);
  assign sum     = count + {{(bdqe_pkg::COUNT_W-2){delta[1]}}, delta};
  // a detent of zero behaves as one
  assign det_u   = (detent_steps == '0) ? bdqe_pkg::DETENT_W'(1) : detent_steps;
  assign det     = {1'b0, det_u};

  assign evt.right = changed && (sum >= det);
  assign evt.left  = changed && !(sum >= det) && (sum <= -det);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= 2'b11;
      count <= '0;
    end else if (fire && changed) begin
      prev  <= cur;
      count <= (evt.right || evt.left) ? '0 : sum;
    end
  end

endmodule

/* rtl/core/bdqe_checker.sv */
// ----------------------------------------------------------------------------
// bdqe_checker: port-level checks
// Watches the top-level ports for pipeline, reset and event-range slips.
// ----------------------------------------------------------------------------
module bdqe_checker #(
  parameter int BUTTON_COUNT = bdqe_pkg::BUTTON_COUNT_DEF,
  parameter int LONG_CAPABLE = bdqe_pkg::LONG_CAPABLE_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bdqe_pkg::EVENT_W-1:0]  event_code
);

  localparam int NLONG    = (LONG_CAPABLE > BUTTON_COUNT) ? BUTTON_COUNT : LONG_CAPABLE;
  localparam int CODE_MAX = BUTTON_COUNT + NLONG + 2;

  // a held result must not change under backpressure
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_code))
    else $error("event_code changed while stalled");

  // the core only refuses a beat when its result register is blocked
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("core not empty after reset");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CODE_MAX > 15) || (event_code <= bdqe_pkg::EVENT_W'(CODE_MAX)))
    else $error("event_code out of range");

endmodule

bind button_debounce_and_quadrature_events_core bdqe_checker #(
  .BUTTON_COUNT (BUTTON_COUNT),
  .LONG_CAPABLE (LONG_CAPABLE)
) u_bdqe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .event_code (event_code)
);
